FILE: rtl/mbe_pkg.sv
`timescale 1ns / 1ps
package mbe_pkg;

	// Q4.28 fixed point throughout the iteration.
	localparam int Q_W       = 32;
	localparam int FRAC_BITS = 28;
	localparam int PROD_W    = 2 * Q_W;
	// Wide enough for every sum that is saturated back to Q4.28.
	localparam int SUM_W     = 38;
	// A square after the shift by FRAC_BITS is non-negative and below 2^35.
	localparam int SQ_W      = 35;

	localparam int COORD_W = 11;
	localparam int STEP_W  = 24;
	localparam int ITER_W  = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	localparam logic [ITER_W-1:0] ITER_CAP = ITER_W'(256);
	// Escape radius squared, 4.0 in Q4.28, at the width of a sum of two squares.
	localparam logic [SQ_W:0] ESCAPE_LIMIT = (SQ_W + 1)'(64'd4 << FRAC_BITS);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd4;

	// Reset values: origin -2.5 - 1.0i and a 256 iteration limit.
	localparam logic signed [Q_W-1:0] RST_X_ORIGIN = -32'sd671088640;
	localparam logic signed [Q_W-1:0] RST_Y_ORIGIN = -32'sd268435456;
	localparam logic [STEP_W-1:0]     RST_X_STEP   = 24'd489335;
	localparam logic [STEP_W-1:0]     RST_Y_STEP   = 24'd497103;
	localparam logic [ITER_W-1:0]     RST_MAX_ITER = 9'd256;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_column;
		logic [COORD_W-1:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic [ITER_W-1:0] iteration_count;
		logic              inside_set;
	} result_t;

	// Operand request to the shared multiplier.
	typedef struct packed {
		logic                    en;
		logic signed [Q_W-1:0]   a;
		logic signed [Q_W-1:0]   b;
	} mul_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAPX,
		ST_MAPY,
		ST_MAPC,
		ST_NEWXY,
		ST_MXX,
		ST_MYY,
		ST_SQY,
		ST_FINISH
	} state_t;

	// Saturate a wide signed sum to the Q4.28 range.
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-Q_W:0] top;
		top = v[SUM_W-1:Q_W-1];
		if ((top == '0) || (top == '1)) begin
			return v[Q_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			return {1'b0, {(Q_W-1){1'b1}}};
		end
	endfunction

endpackage

FILE: rtl/mbe_mul_unit.sv
`timescale 1ns / 1ps
module mbe_mul_unit (
	input  logic                              clk,
	input  mbe_pkg::mul_req_t                 req,
	output logic signed [mbe_pkg::PROD_W-1:0] product_q
);
	import mbe_pkg::*;

	// Exact signed 32 by 32 product, registered; it holds when not requested.
	always_ff @(posedge clk) begin
		if (req.en) begin
			product_q <= req.a * req.b;
		end
	end

endmodule

FILE: rtl/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// Mandelbrot escape-time engine in Q4.28 fixed point.
//
// The pixel channel (in_valid, in_ready, pixel) carries one column and row.
// The point c is formed as origin plus index times step, and z = z*z + c is
// iterated from zero until |z|^2 exceeds 4 or the iteration limit is reached.
// The result channel (out_valid, out_ready, result) returns the iteration count
// and a flag set when the limit was reached. Every pixel gives one result.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); unknown
// indexes are ignored. The user writes it with no pixel in flight (not enforced).
//
// One multiplier is shared by all products under a small sequencer, and a
// pixel takes three products and one update step per iteration; the next
// pixel is taken only once the previous one has left the sequencer.
// The result sits in an output register; a stalled receiver does not stop the
// next pixel from being taken, but a finished pixel waits until the register
// is free. Reset clears the handshake state and loads the default view.
module mandelbrot_escape_time #(
	parameter int MAX_WIDTH  = mbe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mbe_pkg::DEF_MAX_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mbe_pkg::pixel_t                    pixel,
	output logic                               out_valid,
	input  logic                               out_ready,
	output mbe_pkg::result_t                   result,
	input  logic                               cfg_we,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mbe_pkg::*;

	localparam int COL_MAX = MAX_WIDTH - 1;
	localparam int ROW_MAX = MAX_HEIGHT - 1;

	// Configuration registers.
	logic signed [Q_W-1:0] x_origin_q;
	logic signed [Q_W-1:0] y_origin_q;
	logic [STEP_W-1:0]     x_step_q;
	logic [STEP_W-1:0]     y_step_q;
	logic [ITER_W-1:0]     max_iter_q;

	// Per-pixel working registers.
	state_t                state_q, state_d;
	logic [COORD_W-1:0]    col_q, row_q;
	logic [ITER_W-1:0]     limit_q;
	logic [ITER_W-1:0]     iter_q;
	logic signed [Q_W-1:0] cx_q, cy_q, x_q, y_q;
	logic [SQ_W-1:0]       x2_q, y2_q;

	logic                  out_valid_q;
	result_t               result_q;

	mul_req_t                    mul_req;
	logic signed [PROD_W-1:0]    product_q;

	logic                  in_xfer;
	logic                  load_out;
	logic [COORD_W-1:0]    col_clamped, row_clamped;
	logic [ITER_W-1:0]     limit_in;
	logic [SQ_W-1:0]       y2_new;
	logic                  keep_going;
	logic signed [SUM_W-1:0] cx_sum, cy_sum, nx_sum, ny_sum;

	mbe_mul_unit u_mul (
		.clk       (clk),
		.req       (mul_req),
		.product_q (product_q)
	);

	assign in_xfer = in_valid && in_ready;

	// Indexes beyond the frame are pulled back to its last column or row.
	assign col_clamped = (int'(pixel.pixel_column) > COL_MAX) ?
		COORD_W'(COL_MAX) : pixel.pixel_column;
	assign row_clamped = (int'(pixel.pixel_row) > ROW_MAX) ?
		COORD_W'(ROW_MAX) : pixel.pixel_row;
	assign limit_in = (max_iter_q > ITER_CAP) ? ITER_CAP : max_iter_q;

	// The index products are non-negative and below 2^35.
	assign cx_sum = {{(SUM_W-Q_W){x_origin_q[Q_W-1]}}, x_origin_q}
		+ {{(SUM_W-SQ_W){1'b0}}, product_q[SQ_W-1:0]};
	assign cy_sum = {{(SUM_W-Q_W){y_origin_q[Q_W-1]}}, y_origin_q}
		+ {{(SUM_W-SQ_W){1'b0}}, product_q[SQ_W-1:0]};

	// New y is 2*x*y + cy, the doubling folded into a shift one place shorter.
	assign ny_sum = {product_q[PROD_W-1], product_q[PROD_W-1:FRAC_BITS-1]}
		+ {{(SUM_W-Q_W){cy_q[Q_W-1]}}, cy_q};
	assign nx_sum = {{(SUM_W-SQ_W){1'b0}}, x2_q} - {{(SUM_W-SQ_W){1'b0}}, y2_q}
		+ {{(SUM_W-Q_W){cx_q[Q_W-1]}}, cx_q};

	// Squares are non-negative, so the shifted value is a plain part-select.
	assign y2_new = product_q[SQ_W+FRAC_BITS-1:FRAC_BITS];
	assign keep_going = (({1'b0, x2_q} + {1'b0, y2_new}) <= ESCAPE_LIMIT)
		&& (iter_q < limit_q);

	// A finished pixel may move into the output register once it is empty
	// or being emptied in the same cycle.
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		mul_req.en  = 1'b0;
		mul_req.a   = x_q;
		mul_req.b   = y_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MAPX;
				end
			end
			ST_MAPX: begin
				mul_req.en = 1'b1;
				mul_req.a  = Q_W'(col_q);
				mul_req.b  = Q_W'(x_step_q);
				state_d    = ST_MAPY;
			end
			ST_MAPY: begin
				mul_req.en = 1'b1;
				mul_req.a  = Q_W'(row_q);
				mul_req.b  = Q_W'(y_step_q);
				state_d    = ST_MAPC;
			end
			ST_MAPC: begin
				// z starts at zero, so x*y for the first step is zero too.
				mul_req.en = 1'b1;
				mul_req.a  = '0;
				mul_req.b  = '0;
				state_d    = (limit_q == '0) ? ST_FINISH : ST_NEWXY;
			end
			ST_NEWXY: begin
				state_d = ST_MXX;
			end
			ST_MXX: begin
				mul_req.en = 1'b1;
				mul_req.a  = x_q;
				mul_req.b  = x_q;
				state_d    = ST_MYY;
			end
			ST_MYY: begin
				mul_req.en = 1'b1;
				mul_req.a  = y_q;
				mul_req.b  = y_q;
				state_d    = ST_SQY;
			end
			ST_SQY: begin
				// The cross product for the next step is formed while testing.
				mul_req.en = 1'b1;
				mul_req.a  = x_q;
				mul_req.b  = y_q;
				state_d    = keep_going ? ST_NEWXY : ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Working registers carry payload only and need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					col_q   <= col_clamped;
					row_q   <= row_clamped;
					limit_q <= limit_in;
				end
			end
			ST_MAPY: begin
				cx_q <= sat_q(cx_sum);
			end
			ST_MAPC: begin
				cy_q   <= sat_q(cy_sum);
				x_q    <= '0;
				y_q    <= '0;
				x2_q   <= '0;
				y2_q   <= '0;
				iter_q <= '0;
			end
			ST_NEWXY: begin
				x_q    <= sat_q(nx_sum);
				y_q    <= sat_q(ny_sum);
				iter_q <= iter_q + 1'b1;
			end
			ST_MYY: begin
				x2_q <= product_q[SQ_W+FRAC_BITS-1:FRAC_BITS];
			end
			ST_SQY: begin
				y2_q <= y2_new;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= RST_X_ORIGIN;
			y_origin_q <= RST_Y_ORIGIN;
			x_step_q   <= RST_X_STEP;
			y_step_q   <= RST_Y_STEP;
			max_iter_q <= RST_MAX_ITER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_ORIGIN:       x_origin_q <= cfg_data[Q_W-1:0];
				REG_Y_ORIGIN:       y_origin_q <= cfg_data[Q_W-1:0];
				REG_X_STEP:         x_step_q   <= cfg_data[STEP_W-1:0];
				REG_Y_STEP:         y_step_q   <= cfg_data[STEP_W-1:0];
				REG_MAX_ITERATIONS: max_iter_q <= cfg_data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.iteration_count <= iter_q;
			result_q.inside_set      <= (iter_q >= limit_q);
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

`ifndef SYNTHESIS
	// The update step never runs once the limit has been reached.
	a_iter_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEWXY) |-> (iter_q < limit_q))
		else $error("update step entered with the limit already reached");

	// Each update step counts exactly one iteration.
	a_iter_increment: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEWXY) |=> (iter_q == $past(iter_q) + 1'b1))
		else $error("iteration count did not advance by one");

	// A pending result is never overwritten by a finished pixel.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && out_valid_q && !out_ready) |=>
		((state_q == ST_FINISH) && $stable(result_q)))
		else $error("pending result overwritten");

	// An input transfer starts the mapping and closes the input side.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> ((state_q == ST_MAPX) && !in_ready))
		else $error("input transfer did not start the sequencer");

	// The reported count never exceeds the cap.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.iteration_count <= ITER_CAP))
		else $error("iteration count above the cap");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mbe_pkg::*;

	// Spare register indexes: writes to these must leave the view unchanged.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

	// Saturation bounds of a Q4.28 value held in a 64-bit integer.
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	// |z|^2 above 4.0 counts as escaped.
	localparam longint RADIUS_SQ = 64'sd4 <<< FRAC_BITS;

	localparam int PHASES         = 11;
	localparam int PIXELS_PER_VIEW = 100;

	typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

	// One line of the directed table: either a register write or a pixel.
	// Where typed is set, want holds the result read straight off the maths.
	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
		pixel_t                  px;
		bit                      typed;
		result_t                 want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	pixel_t                pixel = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	result_t               result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Our own copy of the view registers, kept in step with every write.
	logic signed [Q_W-1:0] view_x_origin;
	logic signed [Q_W-1:0] view_y_origin;
	logic [STEP_W-1:0]     view_x_step;
	logic [STEP_W-1:0]     view_y_step;
	logic [ITER_W-1:0]     view_max_iter;

	// Escape results still owed by the block, oldest first.
	result_t escape_expected[$];
	dir_row_t dir_rows[$];

	int mismatches = 0;
	int pixels_sent = 0;
	int results_checked = 0;
	int inside_seen = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int stall_left = 0;
	int rx_cycle = 0;

	mandelbrot_escape_time DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns clock, six high and six low.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// A hard stop well beyond the slowest legal run: every pixel at the full
	// 256 iterations plus the longest sender gap and receiver stall.
	initial begin
		#60_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic longint clamp_q(input longint v);
		if (v > Q_MAX) begin
			return Q_MAX;
		end else if (v < Q_MIN) begin
			return Q_MIN;
		end
		return v;
	endfunction

	// Escape-time prediction for one pixel under the current view. Products
	// are exact in 64 bits and then shifted arithmetically, which floors.
	function automatic result_t predict_escape(input pixel_t px);
		longint col, row, cx, cy, x, y, x2, y2, nx, ny;
		int lim, n;
		result_t r;
		col = px.pixel_column;
		row = px.pixel_row;
		if (col > DEF_MAX_WIDTH - 1) begin
			col = DEF_MAX_WIDTH - 1;
		end
		if (row > DEF_MAX_HEIGHT - 1) begin
			row = DEF_MAX_HEIGHT - 1;
		end
		lim = view_max_iter;
		if (lim > 256) begin
			lim = 256;
		end
		cx = clamp_q(longint'(view_x_origin) + col * longint'(view_x_step));
		cy = clamp_q(longint'(view_y_origin) + row * longint'(view_y_step));
		x = 0;
		y = 0;
		x2 = 0;
		y2 = 0;
		n = 0;
		while ((x2 + y2 <= RADIUS_SQ) && (n < lim)) begin
			ny = clamp_q(((x * y) >>> (FRAC_BITS - 1)) + cy);
			nx = clamp_q(x2 - y2 + cx);
			x = nx;
			y = ny;
			x2 = (x * x) >>> FRAC_BITS;
			y2 = (y * y) >>> FRAC_BITS;
			n++;
		end
		r.iteration_count = n[ITER_W-1:0];
		r.inside_set = (n >= lim);
		return r;
	endfunction

	function automatic dir_row_t mk_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		dir_row_t d;
		d.kind = ROW_CFG;
		d.idx = idx;
		d.data = data;
		d.px = '0;
		d.typed = 1'b0;
		d.want = '0;
		return d;
	endfunction

	function automatic dir_row_t mk_pix(input int col, input int row, input bit typed,
			input int count, input bit in_set);
		dir_row_t d;
		d.kind = ROW_PIXEL;
		d.idx = '0;
		d.data = '0;
		d.px.pixel_column = col[COORD_W-1:0];
		d.px.pixel_row = row[COORD_W-1:0];
		d.typed = typed;
		d.want.iteration_count = count[ITER_W-1:0];
		d.want.inside_set = in_set;
		return d;
	endfunction

	// One register write, entered at a falling edge. The enable is dropped after
	// the rising edge that takes it and the task idles once more, so back-to-back
	// calls never raise and lower it within the same time step.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_X_ORIGIN:       view_x_origin = data;
			REG_Y_ORIGIN:       view_y_origin = data;
			REG_X_STEP:         view_x_step = data[STEP_W-1:0];
			REG_Y_STEP:         view_y_step = data[STEP_W-1:0];
			REG_MAX_ITERATIONS: view_max_iter = data[ITER_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_view(input logic [CFG_DATA_W-1:0] xo, input logic [CFG_DATA_W-1:0] yo,
			input logic [CFG_DATA_W-1:0] xs, input logic [CFG_DATA_W-1:0] ys,
			input logic [CFG_DATA_W-1:0] lim);
		cfg_write(REG_X_ORIGIN, xo);
		cfg_write(REG_Y_ORIGIN, yo);
		cfg_write(REG_X_STEP, xs);
		cfg_write(REG_Y_STEP, ys);
		cfg_write(REG_MAX_ITERATIONS, lim);
	endtask

	// Lower valid and wait until every owed result has been seen. Every pixel
	// gives a result, so an empty queue means the engine is idle; an extra wait
	// lets the handshake settle before any register is touched.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (escape_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	// Offer one pixel, entered at a falling edge. The sender runs in bursts:
	// when a burst is used up, valid drops for a random gap. Inside a burst valid
	// stays high from one transfer to the next.
	task automatic send_pixel(input pixel_t px, input result_t want);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		// The transfer happens at this edge; the result is now owed.
		escape_expected.push_back(want);
		pixels_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// The receiver keeps a pattern of its own: each repeating window opens
	// without stalls and then stalls now and then for a random length, so a
	// held result meets every phase of the engine's next pixel.
	always @(negedge clk) begin
		rx_cycle++;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (((rx_cycle % 1000) >= 300) && ($urandom_range(0, 5) == 0)) begin
				stall_left = $urandom_range(1, 20);
			end
		end
	end

	// Every result transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (escape_expected.size() == 0) begin
				$display("%0t: result with none owed, got count %0d inside %0b", $time,
					result.iteration_count, result.inside_set);
				mismatches++;
			end else begin
				want = escape_expected.pop_front();
				if (result.iteration_count !== want.iteration_count) begin
					$display("%0t: iteration_count mismatch, expected %0d, got %0d", $time,
						want.iteration_count, result.iteration_count);
					mismatches++;
				end
				if (result.inside_set !== want.inside_set) begin
					$display("%0t: inside_set mismatch, expected %0b, got %0b", $time,
						want.inside_set, result.inside_set);
					mismatches++;
				end
				results_checked++;
				if (result.inside_set === 1'b1) begin
					inside_seen++;
				end
			end
		end
	end

	initial begin
		pixel_t px;
		result_t want;
		dir_row_t d;
		longint cx0, cy0, xs, ys;
		int mode;
		logic [CFG_DATA_W-1:0] lim;

		view_x_origin = RST_X_ORIGIN;
		view_y_origin = RST_Y_ORIGIN;
		view_x_step = RST_X_STEP;
		view_y_step = RST_Y_STEP;
		view_max_iter = RST_MAX_ITER;

		// Directed table. Under the reset view column 0 row 0 is -2.5 - 1i,
		// which escapes on the first iteration, and column 1371 row 540 lies
		// next to the origin, deep inside the set.
		dir_rows.push_back(mk_pix(0, 0, 1, 1, 0));
		dir_rows.push_back(mk_pix(2047, 2047, 1, 1, 0));
		dir_rows.push_back(mk_pix(1371, 540, 1, 256, 1));
		dir_rows.push_back(mk_pix(11'h555, 11'h2AA, 0, 0, 0));
		dir_rows.push_back(mk_pix(11'h2AA, 11'h555, 0, 0, 0));
		dir_rows.push_back(mk_pix(1024, 1024, 0, 0, 0));
		// A zero limit does no iteration and still reports the point inside.
		dir_rows.push_back(mk_cfg(REG_MAX_ITERATIONS, 32'd0));
		dir_rows.push_back(mk_pix(1371, 540, 1, 0, 1));
		dir_rows.push_back(mk_pix(0, 0, 1, 0, 1));
		// With a limit of one, escaping on that very iteration still counts
		// as inside.
		dir_rows.push_back(mk_cfg(REG_MAX_ITERATIONS, 32'd1));
		dir_rows.push_back(mk_pix(0, 0, 1, 1, 1));
		dir_rows.push_back(mk_pix(1371, 540, 1, 1, 1));
		// A limit above 256 is held at 256.
		dir_rows.push_back(mk_cfg(REG_MAX_ITERATIONS, 32'h1FF));
		dir_rows.push_back(mk_pix(1371, 540, 1, 256, 1));
		dir_rows.push_back(mk_pix(0, 2047, 0, 0, 0));
		// Extreme origins and steps: c sits at or saturates to the edge of Q4.28.
		dir_rows.push_back(mk_cfg(REG_MAX_ITERATIONS, 32'd2));
		dir_rows.push_back(mk_cfg(REG_X_ORIGIN, 32'h7FFF_FFFF));
		dir_rows.push_back(mk_cfg(REG_Y_ORIGIN, 32'h8000_0000));
		dir_rows.push_back(mk_cfg(REG_X_STEP, 32'hFFFF_FFFF));
		dir_rows.push_back(mk_cfg(REG_Y_STEP, 32'h00FF_FFFF));
		dir_rows.push_back(mk_pix(0, 0, 1, 1, 0));
		dir_rows.push_back(mk_pix(2047, 2047, 1, 1, 0));
		dir_rows.push_back(mk_cfg(REG_X_ORIGIN, 32'h8000_0000));
		dir_rows.push_back(mk_cfg(REG_Y_ORIGIN, 32'h7FFF_FFFF));
		dir_rows.push_back(mk_cfg(REG_X_STEP, 32'd0));
		dir_rows.push_back(mk_cfg(REG_Y_STEP, 32'd0));
		dir_rows.push_back(mk_pix(2047, 0, 1, 1, 0));
		// Writes beyond the register list are ignored.
		dir_rows.push_back(mk_cfg(REG_SPARE_A, 32'hFFFF_FFFF));
		dir_rows.push_back(mk_cfg(REG_SPARE_B, 32'd0));
		dir_rows.push_back(mk_cfg(REG_SPARE_C, 32'hA5A5_A5A5));
		dir_rows.push_back(mk_pix(2047, 2047, 1, 1, 0));
		dir_rows.push_back(mk_pix(0, 1024, 0, 0, 0));

		// Reset is held from time zero and then released at a falling edge.
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			d = dir_rows[i];
			if (d.kind == ROW_CFG) begin
				wait_for_results();
				cfg_write(d.idx, d.data);
			end else begin
				want = d.typed ? d.want : predict_escape(d.px);
				send_pixel(d.px, want);
			end
		end

		// Random part: a series of views, each written while the engine is
		// idle and then fed a hundred pixels. The views rotate between the
		// default frame, zooms onto the boundary of the set, fully random
		// registers, extremes, and the default frame at the full limit.
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_for_results();
			mode = phase % 5;
			case (mode)
				0: begin
					lim = ($urandom_range(0, 3) == 0) ? 32'd256 : $urandom_range(1, 48);
					write_view(32'(RST_X_ORIGIN), 32'(RST_Y_ORIGIN), 32'(RST_X_STEP),
						32'(RST_Y_STEP), lim);
				end
				1: begin
					// Centre the frame on a point of the boundary.
					case ($urandom_range(0, 4))
						0: begin cx0 = -201326592; cy0 = 26843546; end
						1: begin cx0 = -26843546; cy0 = 174483046; end
						2: begin cx0 = 75161928; cy0 = 2684355; end
						3: begin cx0 = -335544320; cy0 = 0; end
						default: begin cx0 = -42949673; cy0 = 276488520; end
					endcase
					xs = $urandom_range(0, 8191);
					ys = $urandom_range(0, 8191);
					write_view(32'(cx0 - 1024 * xs), 32'(cy0 - 1024 * ys), 32'(xs),
						32'(ys), $urandom_range(16, 64));
				end
				2: begin
					write_view($urandom, $urandom, $urandom, $urandom, $urandom);
				end
				3: begin
					write_view(($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000,
						($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000,
						($urandom_range(0, 1) != 0) ? 32'h00FF_FFFF : 32'd0,
						($urandom_range(0, 1) != 0) ? 32'h00FF_FFFF : 32'd0,
						$urandom_range(0, 3));
				end
				default: begin
					// The later pass asks for more than 256 iterations.
					lim = (phase > 5) ? $urandom_range(257, 511) : 32'd256;
					write_view(32'(RST_X_ORIGIN), 32'(RST_Y_ORIGIN), 32'(RST_X_STEP),
						32'(RST_Y_STEP), lim);
				end
			endcase
			if ($urandom_range(0, 1) != 0) begin
				cfg_write(REG_SPARE_A + 3'($urandom_range(0, 2)), $urandom);
			end
			for (int k = 0; k < PIXELS_PER_VIEW; k++) begin
				px.pixel_column = ($urandom_range(0, 15) == 0)
					? (($urandom_range(0, 1) != 0) ? 11'h7FF : 11'h000)
					: COORD_W'($urandom);
				px.pixel_row = ($urandom_range(0, 15) == 0)
					? (($urandom_range(0, 1) != 0) ? 11'h7FF : 11'h000)
					: COORD_W'($urandom);
				send_pixel(px, predict_escape(px));
			end
		end

		// Let the last results drain, then watch a little longer for strays.
		wait_for_results();
		repeat (40) @(negedge clk);
		if (escape_expected.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, escape_expected.size());
			mismatches++;
		end

		$display("Sent %0d pixels under %0d register writes; %0d results checked, %0d inside.",
			pixels_sent, reg_writes, results_checked, inside_seen);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
